// ----- src/amic_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package amic_pkg;

  localparam int ADC_W       = 12;
  localparam int LEVEL_W     = 16;
  localparam int CURRENT_W   = 19;
  localparam int REF_W       = 16;
  localparam int WEIGHT_W    = 9;
  localparam int GAIN_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int DEF_MEDIAN_TAPS  = 3;
  localparam int DEF_AVERAGE_TAPS = 5;
  localparam int DEF_SAMPLE_BITS  = 12;

  localparam int DIV_RADIX_BITS = 4;
  localparam int FRAC_BITS      = 4;
  localparam int CURRENT_SHIFT  = 12;
  localparam int CURRENT_HALF   = 2048;
  localparam int IIR_HALF       = 128;
  localparam int CURRENT_LIMIT  = 210000;

  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IIR_WEIGHT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MA_PER_COUNT    = 2'd2;

  localparam logic [REF_W-1:0]    REF_RESET    = 16'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd128;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd12898;

  typedef struct packed {
    logic accept;
    logic avg_update;
    logic div_step;
    logic mul_weight;
    logic mul_comp;
    logic iir_add;
    logic iir_load;
    logic diff_load;
    logic mul_cur;
    logic out_load;
  } amic_cmd_t;

  typedef struct packed {
    logic div_last;
    logic iir_started;
  } amic_status_t;

endpackage

`default_nettype wire

// ----- src/amic_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amic_ctrl import amic_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  amic_status_t status,
  output amic_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AVG  = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_MUL1 = 4'd3;
  localparam logic [3:0] ST_MUL2 = 4'd4;
  localparam logic [3:0] ST_ADD  = 4'd5;
  localparam logic [3:0] ST_DIFF = 4'd6;
  localparam logic [3:0] ST_CUR  = 4'd7;
  localparam logic [3:0] ST_RND  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.avg_update = 1'b1;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (status.iir_started) begin
          cmd.mul_weight = 1'b1;
          state_nxt      = ST_MUL2;
        end else begin
          cmd.iir_load = 1'b1;
          state_nxt    = ST_DIFF;
        end
      end
      ST_MUL2: begin
        cmd.mul_comp = 1'b1;
        state_nxt    = ST_ADD;
      end
      ST_ADD: begin
        cmd.iir_add = 1'b1;
        state_nxt   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_load = 1'b1;
        state_nxt     = ST_CUR;
      end
      ST_CUR: begin
        cmd.mul_cur = 1'b1;
        state_nxt   = ST_RND;
      end
      ST_RND: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_average: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_AVG)
    else $error("accepted beat did not start the average step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");
`endif

endmodule

`default_nettype wire

// ----- src/amic_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amic_dp import amic_pkg::*; #(
  parameter int MEDIAN_TAPS  = DEF_MEDIAN_TAPS,
  parameter int AVERAGE_TAPS = DEF_AVERAGE_TAPS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ADC_W-1:0]            in_adc_sample,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  amic_cmd_t                   cmd,
  output amic_status_t                status,
  output logic [LEVEL_W-1:0]          out_filtered_level,
  output logic signed [CURRENT_W-1:0] out_current_ma
);

  localparam int MP_W      = $clog2(MEDIAN_TAPS);
  localparam int RANK_W    = $clog2(MEDIAN_TAPS);
  localparam int MID       = MEDIAN_TAPS / 2;
  localparam int AP_W      = $clog2(AVERAGE_TAPS);
  localparam int D_W       = $clog2(AVERAGE_TAPS + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
  localparam int LVL_W     = SAMPLE_BITS + FRAC_BITS;
  localparam int DVD_W     = SUM_W + FRAC_BITS;
  localparam int DIV_STEPS = (DVD_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int PAD_W     = DIV_STEPS * DIV_RADIX_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int DIFF_W    = ((LVL_W > REF_W) ? LVL_W : REF_W) + 1;
  localparam int MB_W      = GAIN_W + 1;
  localparam int PROD_W    = DIFF_W + MB_W;
  localparam int ACC_W     = LVL_W + 8;

  // configuration
  logic [REF_W-1:0]    ref_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [GAIN_W-1:0]   gain_r;

  // filter state
  logic [SAMPLE_BITS-1:0] mring_r [MEDIAN_TAPS];
  logic [MP_W-1:0]        mptr_r;
  logic [SAMPLE_BITS-1:0] aring_r [AVERAGE_TAPS];
  logic [SUM_W-1:0]       sum_r;
  logic [AP_W-1:0]        aptr_r;
  logic                   full_r;
  logic [LVL_W-1:0]       level_r;
  logic                   started_r;

  // work registers
  logic [SAMPLE_BITS-1:0]    med_r;
  logic [PAD_W-1:0]          dvd_r;
  logic [PAD_W-1:0]          q_r;
  logic [D_W-1:0]            rem_r;
  logic [D_W-1:0]            d_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]          acc_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic [LEVEL_W-1:0]        out_level_r;
  logic [CURRENT_W-1:0]      out_cur_r;

  // sample and median
  logic [SAMPLE_BITS+ADC_W-1:0] samp_ext;
  logic [SAMPLE_BITS-1:0]       sample;
  logic [SAMPLE_BITS-1:0]       mval [MEDIAN_TAPS];
  logic [RANK_W-1:0]            rank [MEDIAN_TAPS];
  logic [SAMPLE_BITS-1:0]       median;
  logic [MP_W-1:0]              mptr_nxt;

  assign samp_ext = {{SAMPLE_BITS{1'b0}}, in_adc_sample};
  assign sample   = samp_ext[SAMPLE_BITS-1:0];
  assign mptr_nxt = (mptr_r == MP_W'(MEDIAN_TAPS - 1)) ? '0 : mptr_r + 1'b1;

  always_comb begin
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      mval[i] = (mptr_r == MP_W'(i)) ? sample : mring_r[i];
    end
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if (j != i) begin
          if ((mval[j] < mval[i]) || ((mval[j] == mval[i]) && (j < i))) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
    end
    median = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        median = median | mval[i];
      end
    end
  end

  // moving average
  logic [SAMPLE_BITS-1:0] avg_old;
  logic [SUM_W-1:0]       sum_nxt;
  logic [AP_W-1:0]        aptr_nxt;
  logic                   full_nxt;
  logic [D_W-1:0]         d_nxt;
  logic [DVD_W-1:0]       dvd_init;

  assign avg_old  = aring_r[aptr_r];
  assign sum_nxt  = sum_r - SUM_W'(avg_old) + SUM_W'(med_r);
  assign aptr_nxt = (aptr_r == AP_W'(AVERAGE_TAPS - 1)) ? '0 : aptr_r + 1'b1;
  assign full_nxt = full_r | (aptr_r == AP_W'(AVERAGE_TAPS - 1));
  assign d_nxt    = full_nxt ? D_W'(AVERAGE_TAPS) : D_W'(aptr_nxt);
  assign dvd_init = {sum_nxt, {FRAC_BITS{1'b0}}} + DVD_W'(d_nxt >> 1);

  // divider, DIV_RADIX_BITS quotient bits a step
  logic [D_W:0]                trial;
  logic [D_W-1:0]              rem_t;
  logic [DIV_RADIX_BITS-1:0]   qbits;

  always_comb begin
    rem_t = rem_r;
    qbits = '0;
    trial = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial = {rem_t, dvd_r[PAD_W-1-k]};
      if (trial >= {1'b0, d_r}) begin
        trial = trial - {1'b0, d_r};
        qbits[DIV_RADIX_BITS-1-k] = 1'b1;
      end
      rem_t = trial[D_W-1:0];
    end
  end

  assign status.div_last    = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign status.iir_started = started_r;

  // shared multiplier
  logic [LVL_W-1:0]         avg_q;
  logic [WEIGHT_W-1:0]      w_eff;
  logic [WEIGHT_W-1:0]      w_comp;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0]         iir_sum;

  assign avg_q  = q_r[LVL_W-1:0];
  assign w_eff  = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_comp = WEIGHT_ONE - w_eff;

  always_comb begin
    mul_a = diff_r;
    mul_b = $signed({1'b0, gain_r});
    if (cmd.mul_weight) begin
      mul_a = $signed(DIFF_W'(avg_q));
      mul_b = $signed(MB_W'(w_eff));
    end else if (cmd.mul_comp) begin
      mul_a = $signed(DIFF_W'(level_r));
      mul_b = $signed(MB_W'(w_comp));
    end
  end

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign iir_sum = acc_r + prod_r[ACC_W-1:0];

  // rounding to milliamps and saturation
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] cur_full;
  logic signed [PROD_W-1:0] cur_sat;
  logic [LVL_W+LEVEL_W-1:0] lvl_ext;

  assign rnd = prod_r + $signed(PROD_W'(CURRENT_HALF))
             - $signed(PROD_W'(prod_r[PROD_W-1]));
  assign cur_full = rnd >>> CURRENT_SHIFT;
  assign lvl_ext  = {{LEVEL_W{1'b0}}, level_r};

  always_comb begin
    cur_sat = cur_full;
    if (cur_full > PROD_W'(CURRENT_LIMIT)) begin
      cur_sat = PROD_W'(CURRENT_LIMIT);
    end else if (cur_full < PROD_W'(-CURRENT_LIMIT)) begin
      cur_sat = PROD_W'(-CURRENT_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= REF_RESET;
      weight_r <= WEIGHT_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REFERENCE_LEVEL: ref_r    <= cfg_data[REF_W-1:0];
        REG_IIR_WEIGHT:      weight_r <= cfg_data[WEIGHT_W-1:0];
        REG_MA_PER_COUNT:    gain_r   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        mring_r[i] <= '0;
      end
      for (int i = 0; i < AVERAGE_TAPS; i++) begin
        aring_r[i] <= '0;
      end
      mptr_r    <= '0;
      sum_r     <= '0;
      aptr_r    <= '0;
      full_r    <= 1'b0;
      level_r   <= '0;
      started_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mring_r[mptr_r] <= sample;
        mptr_r          <= mptr_nxt;
      end
      if (cmd.avg_update) begin
        aring_r[aptr_r] <= med_r;
        sum_r           <= sum_nxt;
        aptr_r          <= aptr_nxt;
        full_r          <= full_nxt;
      end
      if (cmd.iir_load) begin
        level_r   <= avg_q;
        started_r <= 1'b1;
      end else if (cmd.iir_add) begin
        level_r <= iir_sum[ACC_W-1:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      med_r <= median;
    end
    if (cmd.avg_update) begin
      dvd_r <= PAD_W'(dvd_init);
      rem_r <= '0;
      d_r   <= d_nxt;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << DIV_RADIX_BITS;
      q_r   <= {q_r[PAD_W-DIV_RADIX_BITS-1:0], qbits};
      rem_r <= rem_t;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul_weight || cmd.mul_comp || cmd.mul_cur) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_comp) begin
      acc_r <= prod_r[ACC_W-1:0] + ACC_W'(IIR_HALF);
    end
    if (cmd.diff_load) begin
      diff_r <= $signed(DIFF_W'(level_r) - DIFF_W'(ref_r));
    end
    if (cmd.out_load) begin
      out_level_r <= lvl_ext[LEVEL_W-1:0];
      out_cur_r   <= cur_sat[CURRENT_W-1:0];
    end
  end

  assign out_filtered_level = out_level_r;
  assign out_current_ma     = $signed(out_cur_r);

`ifndef NO_ASSERTIONS
  a_window_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("window_full dropped without reset");

  a_average_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
    aptr_r <= AP_W'(AVERAGE_TAPS - 1))
    else $error("average pointer out of range");

  a_median_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
    mptr_r <= MP_W'(MEDIAN_TAPS - 1))
    else $error("median pointer out of range");

  a_divider_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step && status.div_last |=> rem_r < d_r)
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- src/adc_median_average_iir_chain_unit.sv -----
// ADC filter cascade for a Hall current sensor: each input beat carries one raw
// sample, which runs through a MEDIAN_TAPS-tap running median, an AVERAGE_TAPS-tap
// moving average (dividing by the sample count until the window first fills) and a
// first-order IIR whose first input loads directly; each result beat carries the
// level in Q12.4 counts and the current (level - reference) * gain in milliamps,
// rounded and saturated to +/-210000. One sample is in work at a time: each item
// runs through the radix-16 average divider and the single shared multiplier, used
// three times per item (once for the first item after reset, whose IIR input loads
// directly); a result left unread holds its item in the rounding state. The input
// may be accepted while the previous result still waits in the output register.
// Configuration writes are always ready and are to be issued only while the block
// is idle.
`timescale 1ns / 1ps
`default_nettype none

module adc_median_average_iir_chain_unit import amic_pkg::*; #(
  parameter int MEDIAN_TAPS  = DEF_MEDIAN_TAPS,
  parameter int AVERAGE_TAPS = DEF_AVERAGE_TAPS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ADC_W-1:0]            in_adc_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [LEVEL_W-1:0]          out_filtered_level,
  output logic signed [CURRENT_W-1:0] out_current_ma,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  amic_cmd_t    cmd;
  amic_status_t status;

  assign cfg_ready = 1'b1;

  amic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  amic_dp #(
    .MEDIAN_TAPS  (MEDIAN_TAPS),
    .AVERAGE_TAPS (AVERAGE_TAPS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_adc_sample      (in_adc_sample),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .status             (status),
    .out_filtered_level (out_filtered_level),
    .out_current_ma     (out_current_ma)
  );

endmodule

`default_nettype wire

// ----- bench/amic_result_checker.sv -----
`timescale 1ns / 1ps

module amic_result_checker import amic_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [ADC_W-1:0]            in_adc_sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [LEVEL_W-1:0]          out_filtered_level,
  input  logic signed [CURRENT_W-1:0] out_current_ma,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output int                          mismatch_count,
  output int                          readings_pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0]          level;
    logic signed [CURRENT_W-1:0] current;
  } reading_t;

  logic [REF_W-1:0]    zero_ref;
  logic [WEIGHT_W-1:0] weight;
  logic [GAIN_W-1:0]   gain;

  logic [ADC_W-1:0] med_hist [DEF_MEDIAN_TAPS];
  int               med_ptr;
  logic [ADC_W-1:0] avg_hist [DEF_AVERAGE_TAPS];
  int unsigned      avg_total;
  int               avg_ptr;
  bit               avg_full;
  logic [LEVEL_W-1:0] smooth_level;
  bit               smooth_loaded;

  reading_t pending_readings[$];
  reading_t want;
  int       mismatches = 0;

  function automatic reading_t filter_sample(logic [ADC_W-1:0] sample);
    logic [ADC_W-1:0] sorted [DEF_MEDIAN_TAPS];
    logic [ADC_W-1:0] key;
    int               i;
    int               j;
    int unsigned      divisor;
    int unsigned      averaged;
    longint unsigned  w;
    longint unsigned  acc;
    longint           delta;
    longint           product;
    longint           amps;
    reading_t         r;
    med_hist[med_ptr] = sample;
    med_ptr = (med_ptr + 1) % DEF_MEDIAN_TAPS;
    sorted = med_hist;
    for (i = 0; i < DEF_MEDIAN_TAPS - 1; i++) begin
      for (j = 0; j < DEF_MEDIAN_TAPS - 1 - i; j++) begin
        if (sorted[j] > sorted[j+1]) begin
          key = sorted[j];
          sorted[j] = sorted[j+1];
          sorted[j+1] = key;
        end
      end
    end

    avg_total = avg_total - avg_hist[avg_ptr] + sorted[DEF_MEDIAN_TAPS/2];
    avg_hist[avg_ptr] = sorted[DEF_MEDIAN_TAPS/2];
    avg_ptr = (avg_ptr + 1) % DEF_AVERAGE_TAPS;
    if (avg_ptr == 0) avg_full = 1'b1;
    divisor = avg_full ? DEF_AVERAGE_TAPS : avg_ptr;
    averaged = ((avg_total << FRAC_BITS) + divisor / 2) / divisor;

    w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    if (!smooth_loaded) begin
      smooth_level = averaged[LEVEL_W-1:0];
      smooth_loaded = 1'b1;
    end else begin
      acc = w * averaged + (WEIGHT_ONE - w) * smooth_level + IIR_HALF;
      smooth_level = acc[LEVEL_W+7:8];
    end

    delta = longint'(smooth_level) - longint'(zero_ref);
    product = delta * longint'(gain);
    if (product >= 0) amps = (product + CURRENT_HALF) >>> CURRENT_SHIFT;
    else amps = -((-product + CURRENT_HALF) >>> CURRENT_SHIFT);
    if (amps > CURRENT_LIMIT) amps = CURRENT_LIMIT;
    else if (amps < -CURRENT_LIMIT) amps = -CURRENT_LIMIT;

    r.level = smooth_level;
    r.current = amps[CURRENT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      zero_ref = REF_RESET;
      weight = WEIGHT_RESET;
      gain = GAIN_RESET;
      foreach (med_hist[k]) med_hist[k] = '0;
      foreach (avg_hist[k]) avg_hist[k] = '0;
      med_ptr = 0;
      avg_ptr = 0;
      avg_total = 0;
      avg_full = 1'b0;
      smooth_level = '0;
      smooth_loaded = 1'b0;
      pending_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REFERENCE_LEVEL: zero_ref = cfg_data;
          REG_IIR_WEIGHT:      weight = cfg_data[WEIGHT_W-1:0];
          REG_MA_PER_COUNT:    gain = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_readings.push_back(filter_sample(in_adc_sample));
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $error("result beat with nothing expected: filtered_level %0d current_ma %0d",
                 out_filtered_level, out_current_ma);
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if (out_filtered_level !== want.level) begin
            $error("filtered_level mismatch: expected %0d, actual %0d",
                   want.level, out_filtered_level);
            mismatches++;
          end
          if (out_current_ma !== want.current) begin
            $error("current_ma mismatch: expected %0d, actual %0d",
                   want.current, out_current_ma);
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    readings_pending <= pending_readings.size();
  end

endmodule

// ----- bench/tb_adc_median_average_iir_chain_unit.sv -----
`timescale 1ns / 1ps

module tb_adc_median_average_iir_chain_unit;
  import amic_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SAMPLE_MAX      = (1 << ADC_W) - 1;
  localparam int RANDOM_SAMPLES  = 1800;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 600000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ADC_W-1:0]            in_adc_sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [LEVEL_W-1:0]          out_filtered_level;
  logic signed [CURRENT_W-1:0] out_current_ma;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int mismatch_count;
  int readings_pending;
  int cycle_count = 0;
  int noise_center = 2048;
  bit random_phase = 1'b0;

  always #5 clk = ~clk;

  adc_median_average_iir_chain_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_level (out_filtered_level),
    .out_current_ma     (out_current_ma),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  amic_result_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_level (out_filtered_level),
    .out_current_ma     (out_current_ma),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .readings_pending   (readings_pending)
  );

  // hold valid high across back-to-back beats; the caller lowers it
  task automatic send_sample(input logic [ADC_W-1:0] value);
    in_valid <= 1'b1;
    in_adc_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic rest_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] ref_data,
                           input logic [CFG_DATA_W-1:0] weight_data,
                           input logic [CFG_DATA_W-1:0] gain_data,
                           input bit with_unused);
    drain();
    write_reg(REG_REFERENCE_LEVEL, ref_data);
    write_reg(REG_IIR_WEIGHT, weight_data);
    write_reg(REG_MA_PER_COUNT, gain_data);
    if (with_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_reg(input logic [CFG_INDEX_W-1:0] index);
    int pick;
    pick = $urandom_range(0, 7);
    case (index)
      REG_REFERENCE_LEVEL: begin
        if (pick == 0) return '0;
        if (pick == 1) return 16'd65520;
        if (pick == 2) return 16'hFFFF;
        if (pick < 5) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(16 * 1024, 16 * 3072));
      end
      REG_IIR_WEIGHT: begin
        if (pick == 0) return '0;
        if (pick == 1) return CFG_DATA_W'(WEIGHT_ONE);
        if (pick == 2) return CFG_DATA_W'($urandom_range(257, 511));
        if (pick == 3) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(1, 255));
      end
      default: begin
        if (pick == 0) return '0;
        if (pick == 1) return 16'hFFFF;
        if (pick < 4) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(8000, 16000));
      end
    endcase
  endfunction

  // mostly a drifting level with sensor noise, plus full-range values and spikes
  function automatic logic [ADC_W-1:0] next_sample();
    int pick;
    int value;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      value = int'($urandom_range(0, SAMPLE_MAX));
    end else if (pick == 2) begin
      value = $urandom_range(0, 1) ? SAMPLE_MAX - int'($urandom_range(0, 3))
                                   : int'($urandom_range(0, 3));
    end else if (pick == 3) begin
      value = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
    end else begin
      noise_center = noise_center + int'($urandom_range(0, 64)) - 32;
      if (noise_center < 0) noise_center = 0;
      if (noise_center > SAMPLE_MAX) noise_center = SAMPLE_MAX;
      value = noise_center + int'($urandom_range(0, 40)) - 20;
    end
    if (value < 0) value = 0;
    if (value > SAMPLE_MAX) value = SAMPLE_MAX;
    return value[ADC_W-1:0];
  endfunction

  initial begin
    int sent;
    int phase_len;
    int burst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first sample loads the IIR; average divides by the count until full
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    rest_input(3);
    send_sample(12'h000);
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'h000);

    // reference above level range, weight above one with stray high bits
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h000);

    // positive saturation
    configure(16'd0, 16'd257, 16'hFFFF, 1'b0);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'hFFF);

    // weight zero holds the level
    configure(16'd65520, 16'd0, 16'd1, 1'b0);
    send_sample(12'h000);
    send_sample(12'h800);

    configure(16'd32768, CFG_DATA_W'(WEIGHT_ONE), 16'd0, 1'b0);
    send_sample(12'd1000);
    send_sample(12'd3000);

    configure(16'd32768, CFG_DATA_W'(WEIGHT_RESET), CFG_DATA_W'(GAIN_RESET), 1'b1);
    random_phase <= 1'b1;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      phase_len = $urandom_range(100, 300);
      while (phase_len > 0 && sent < RANDOM_SAMPLES) begin
        burst = $urandom_range(1, 50);
        while (burst > 0 && phase_len > 0 && sent < RANDOM_SAMPLES) begin
          send_sample(next_sample());
          burst--;
          phase_len--;
          sent++;
        end
        rest_input($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 15));
      end
      if (sent < RANDOM_SAMPLES)
        configure(random_reg(REG_REFERENCE_LEVEL), random_reg(REG_IIR_WEIGHT),
                  random_reg(REG_MA_PER_COUNT), $urandom_range(0, 3) == 0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit held_off;
    int mode;
    int span;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (random_phase && !held_off) begin
        // hold off long enough for the block to back up into its input
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 80);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= (k % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
